FILE: sv/assert_macros.svh
// Assertion macros shared by the armor aim point selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define AAPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold at a clock edge.
`define AAPS_NEVER(label, cond, msg) \
    `AAPS_ASSERT(label, !(cond), msg)

`endif

FILE: sv/aaps_pkg.sv
// Package: types, constants and the CORDIC arctangent table for the aim point selector.
package aaps_pkg;

    localparam int COORD_W   = 16;
    localparam int RATE_W    = 16;
    localparam int YAW_W     = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 3;
    localparam int PLATE_W   = 2;
    localparam int LOCK_W    = 3;

    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = 5;
    localparam int CORDIC_W     = 34;
    localparam int PRESCALE     = 14;
    localparam int ACC_W        = 32;

    localparam logic [LOCK_W-1:0] NO_LOCK = 3'd4;

    localparam logic signed [RATE_W-1:0] SLOW_SPIN_LIMIT = 16'sd512;

    // 60, 70 and 30 degrees in units of 2^-24 turn
    localparam int TH60_Q24 = 2795997;
    localparam int TH70_Q24 = 3261996;
    localparam int TH30_Q24 = 1397998;

    localparam logic [CFG_IDX_W-1:0] REG_COMING_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVING_LIMIT = 2'd1;

    localparam logic [CFG_W-1:0] COMING_WINDOW_RST = 15'd10923;
    localparam logic [CFG_W-1:0] LEAVING_LIMIT_RST = 15'd3641;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_PLATES,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic commit;
    } plate_ctrl_t;

    typedef struct packed {
        logic               aim_valid;
        logic [PLATE_W-1:0] plate_index;
    } aim_result_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [ACC_W-1:0] val;
        unique case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051D;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2E;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2F9;
            5'd15:   val = 32'h0000517C;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A2F;
            5'd19:   val = 32'h00000517;
            5'd20:   val = 32'h0000028B;
            5'd21:   val = 32'h00000145;
            5'd22:   val = 32'h000000A2;
            5'd23:   val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: sv/aaps_cordic.sv
// Iterative CORDIC vectoring unit: centre yaw as atan2(z, x), one micro-rotation per cycle.
`include "assert_macros.svh"

module aaps_cordic
    import aaps_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [COORD_W-1:0]   center_x,
    input  logic signed [COORD_W-1:0]   center_z,
    output logic                        busy,
    output logic                        done,
    output logic [ANGLE_BITS-1:0]       angle
);

    localparam int SEXT_W = CORDIC_W - COORD_W - PRESCALE;
    localparam logic [ACC_W-1:0] ROUND_INC = 32'd1 << (ACC_W - 1 - ANGLE_BITS);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic                       zero_reg, zero_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;

    logic signed [CORDIC_W-1:0] x_scaled, z_scaled;
    logic signed [CORDIC_W-1:0] x_shr, y_shr;
    logic [ACC_W-1:0]           round_sum;

    assign x_scaled = {{SEXT_W{center_x[COORD_W-1]}}, center_x, {PRESCALE{1'b0}}};
    assign z_scaled = {{SEXT_W{center_z[COORD_W-1]}}, center_z, {PRESCALE{1'b0}}};

    assign x_shr = x_reg >>> iter_reg;
    assign y_shr = y_reg >>> iter_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        zero_next = zero_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            zero_next = (center_x == '0) && (center_z == '0);
            // fold the left half plane onto the right, starting from pi
            if (center_x[COORD_W-1])
            begin
                x_next   = -x_scaled;
                y_next   = -z_scaled;
                acc_next = 32'h8000_0000;
            end
            else
            begin
                x_next   = x_scaled;
                y_next   = z_scaled;
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[CORDIC_W-1])
            begin
                x_next   = x_reg + y_shr;
                y_next   = y_reg - x_shr;
                acc_next = acc_reg + atan_entry(iter_reg);
            end
            else
            begin
                x_next   = x_reg - y_shr;
                y_next   = y_reg + x_shr;
                acc_next = acc_reg - atan_entry(iter_reg);
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
    end

    // round the accumulator to the output angle width
    assign round_sum = acc_reg + ROUND_INC;
    assign angle     = zero_reg ? '0 : round_sum[ACC_W-1 -: ANGLE_BITS];
    assign busy      = busy_reg;
    assign done      = done_reg;

    `AAPS_ASSERT(a_cordic_latency, start |-> ##25 done_reg,
                 "CORDIC result did not arrive 25 cycles after start")
    `AAPS_NEVER(a_cordic_restart, start && busy_reg,
                "CORDIC started while an atan2 was still running")

endmodule

FILE: sv/aaps_plate_eval.sv
// Plate evaluator: wraps one plate offset per step, tracks candidates and the plate lock.
`include "assert_macros.svh"

module aaps_plate_eval
    import aaps_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  plate_ctrl_t               ctrl,
    input  logic [ANGLE_BITS-1:0]     center,
    input  logic signed [YAW_W-1:0]   yaw,
    input  logic [PLATE_W-1:0]        plate_id,
    input  logic                      slow_mode,
    input  logic                      outpost,
    input  logic                      turn_pos,
    input  logic                      turn_neg,
    input  logic [CFG_W-1:0]          coming_window,
    input  logic [CFG_W-1:0]          leaving_limit,
    output aim_result_t               result
);

    localparam int AB       = ANGLE_BITS;
    localparam int TH_SHIFT = (AB >= 24) ? 0 : 24 - AB;
    localparam int TH_ROUND = (TH_SHIFT > 0) ? (1 << ((TH_SHIFT > 0) ? TH_SHIFT - 1 : 0)) : 0;
    localparam logic [AB-1:0] TH60 = AB'((TH60_Q24 + TH_ROUND) >> TH_SHIFT);
    localparam logic [AB-1:0] TH70 = AB'((TH70_Q24 + TH_ROUND) >> TH_SHIFT);
    localparam logic [AB-1:0] TH30 = AB'((TH30_Q24 + TH_ROUND) >> TH_SHIFT);

    logic [1:0]          n_reg, n_next;
    logic [PLATE_W-1:0]  id0_reg, id0_next;
    logic [PLATE_W-1:0]  id1_reg, id1_next;
    logic [AB-1:0]       mag0_reg, mag0_next;
    logic [AB-1:0]       mag1_reg, mag1_next;
    logic                found_reg, found_next;
    logic [PLATE_W-1:0]  found_id_reg, found_id_next;
    logic [LOCK_W-1:0]   lock_reg, lock_next;

    logic [AB-1:0]       yaw_sc, cw_sc, ll_sc;
    logic [YAW_W-1:0]    cw16, ll16;
    logic [AB-1:0]       delta, mag, win, leave;
    logic signed [AB:0]  delta_x, leave_x;
    logic                slow_hit, spin_hit;
    logic [LOCK_W-1:0]   lock_pick;

    assign cw16 = {1'b0, coming_window};
    assign ll16 = {1'b0, leaving_limit};

    // bring 16-bit binary angles to the working angle width
    generate
        if (AB > YAW_W)
        begin : g_scale_up
            assign yaw_sc = {yaw,  {(AB - YAW_W){1'b0}}};
            assign cw_sc  = {cw16, {(AB - YAW_W){1'b0}}};
            assign ll_sc  = {ll16, {(AB - YAW_W){1'b0}}};
        end
        else if (AB == YAW_W)
        begin : g_scale_same
            assign yaw_sc = yaw;
            assign cw_sc  = cw16;
            assign ll_sc  = ll16;
        end
        else
        begin : g_scale_down
            assign yaw_sc = yaw[YAW_W-1 -: AB];
            assign cw_sc  = cw16[YAW_W-1 -: AB];
            assign ll_sc  = ll16[YAW_W-1 -: AB];
        end
    endgenerate

    // wrapped offset; exactly half a turn reads as -pi
    assign delta   = yaw_sc - center;
    assign mag     = delta[AB-1] ? (~delta + 1'b1) : delta;
    assign win     = outpost ? TH70 : cw_sc;
    assign leave   = outpost ? TH30 : ll_sc;
    assign delta_x = $signed({delta[AB-1], delta});
    assign leave_x = $signed({1'b0, leave});

    assign slow_hit = (mag <= TH60);
    assign spin_hit = (mag <= win) &&
                      ((turn_pos && (delta_x < leave_x)) || (turn_neg && (delta_x > -leave_x)));

    // keep the lock if it is one of the first two candidates, else take the nearer one
    assign lock_pick = ((lock_reg != LOCK_W'(id0_reg)) && (lock_reg != LOCK_W'(id1_reg)))
                       ? ((mag0_reg < mag1_reg) ? LOCK_W'(id0_reg) : LOCK_W'(id1_reg))
                       : lock_reg;

    always_comb
    begin
        n_next        = n_reg;
        id0_next      = id0_reg;
        id1_next      = id1_reg;
        mag0_next     = mag0_reg;
        mag1_next     = mag1_reg;
        found_next    = found_reg;
        found_id_next = found_id_reg;
        lock_next     = lock_reg;
        result        = '{aim_valid: 1'b0, plate_index: '0};

        if (ctrl.clear)
        begin
            n_next     = '0;
            found_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (slow_hit)
            begin
                case (n_reg)
                    2'd0:
                    begin
                        id0_next  = plate_id;
                        mag0_next = mag;
                        n_next    = 2'd1;
                    end
                    2'd1:
                    begin
                        id1_next  = plate_id;
                        mag1_next = mag;
                        n_next    = 2'd2;
                    end
                    default: n_next = n_reg;
                endcase
            end
            if (!found_reg && spin_hit)
            begin
                found_next    = 1'b1;
                found_id_next = plate_id;
            end
        end
        else if (ctrl.commit)
        begin
            if (slow_mode)
            begin
                case (n_reg)
                    2'd0:
                    begin
                        result = '{aim_valid: 1'b0, plate_index: '0};
                    end
                    2'd1:
                    begin
                        lock_next = NO_LOCK;
                        result    = '{aim_valid: 1'b1, plate_index: id0_reg};
                    end
                    default:
                    begin
                        lock_next = lock_pick;
                        result    = '{aim_valid: 1'b1, plate_index: lock_pick[PLATE_W-1:0]};
                    end
                endcase
            end
            else if (found_reg)
            begin
                result = '{aim_valid: 1'b1, plate_index: found_id_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            found_reg <= 1'b0;
            lock_reg  <= NO_LOCK;
        end
        else
        begin
            n_reg     <= n_next;
            found_reg <= found_next;
            lock_reg  <= lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id0_reg      <= id0_next;
        id1_reg      <= id1_next;
        mag0_reg     <= mag0_next;
        mag1_reg     <= mag1_next;
        found_id_reg <= found_id_next;
    end

    `AAPS_ASSERT(a_lock_range, lock_reg <= NO_LOCK,
                 "plate lock holds a code above the no-lock value")
    `AAPS_ASSERT(a_single_unlocks, (ctrl.commit && slow_mode && n_reg == 2'd1)
                 |=> (lock_reg == NO_LOCK),
                 "single slow-mode candidate did not release the lock")

endmodule

FILE: sv/armor_aim_point_selector_top.sv
// Top level: handshakes, configuration registers, sequencer and output register.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------------
//  in      | in  | in_valid / in_stall | center_x, center_z, turn_rate, spin_rate,
//          |     |                     | is_outpost, jumped, armor_count, armor_yaw_0..3
//  out     | out | out_valid/out_stall | aim_valid, plate_index
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item that has not jumped goes from acceptance straight to ST_RESULT and back to ST_IDLE.
// A jumped item passes ST_CORDIC for the 24 CORDIC iterations, then ST_PLATES for one
// offset evaluation per plate on the shared compare path, then ST_RESULT.
// in_stall is high from acceptance until the result moves into the output register;
// a stalled output register holds only the finished item, the next one may be taken.
// Reset is asynchronous, active low; it clears the lock and restores both registers.
`include "assert_macros.svh"

module armor_aim_point_selector_top
    import aaps_pkg::*;
#(
    parameter int MAX_PLATES = 4,
    parameter int ANGLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_z,
    input  logic signed [RATE_W-1:0]  turn_rate,
    input  logic signed [RATE_W-1:0]  spin_rate,
    input  logic                      is_outpost,
    input  logic                      jumped,
    input  logic [COUNT_W-1:0]        armor_count,
    input  logic signed [YAW_W-1:0]   armor_yaw_0,
    input  logic signed [YAW_W-1:0]   armor_yaw_1,
    input  logic signed [YAW_W-1:0]   armor_yaw_2,
    input  logic signed [YAW_W-1:0]   armor_yaw_3,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      aim_valid,
    output logic [PLATE_W-1:0]        plate_index,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int PIDX_W = (MAX_PLATES > 2) ? 2 : 1;

    seq_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    aim_result_t         res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic                aim_valid_reg;
    logic [PLATE_W-1:0]  plate_index_reg;
    logic [CFG_W-1:0]    coming_window_reg, coming_window_next;
    logic [CFG_W-1:0]    leaving_limit_reg, leaving_limit_next;

    logic                slow_reg, outpost_reg, turn_pos_reg, turn_neg_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic signed [YAW_W-1:0] yaw_reg [MAX_PLATES];
    logic signed [YAW_W-1:0] yaw_in [4];

    logic                in_accept, load_out;
    logic                cordic_start, cordic_busy, cordic_done;
    logic [ANGLE_BITS-1:0] hub_angle;
    logic [COUNT_W-1:0]  count_in;
    logic                slow_in;
    plate_ctrl_t         plate_ctrl;
    aim_result_t         plate_res;

    assign yaw_in[0] = armor_yaw_0;
    assign yaw_in[1] = armor_yaw_1;
    assign yaw_in[2] = armor_yaw_2;
    assign yaw_in[3] = armor_yaw_3;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign count_in = (armor_count > COUNT_W'(MAX_PLATES)) ? COUNT_W'(MAX_PLATES) : armor_count;
    assign slow_in  = (spin_rate >= -SLOW_SPIN_LIMIT) && (spin_rate <= SLOW_SPIN_LIMIT) &&
                      !is_outpost;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        plate_ctrl   = '0;
        cordic_start = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (jumped)
                    begin
                        cordic_start = 1'b1;
                        state_next   = ST_CORDIC;
                    end
                    else
                    begin
                        res_next   = '{aim_valid: 1'b1, plate_index: '0};
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                begin
                    plate_ctrl.clear = 1'b1;
                    cnt_next         = '0;
                    state_next       = ST_PLATES;
                end
            end
            ST_PLATES:
            begin
                if (cnt_reg == count_reg)
                begin
                    plate_ctrl.commit = 1'b1;
                    res_next          = plate_res;
                    state_next        = ST_RESULT;
                end
                else
                begin
                    plate_ctrl.step = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                // hand over once the output register is free or draining
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        coming_window_next = coming_window_reg;
        leaving_limit_next = leaving_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COMING_WINDOW: coming_window_next = cfg_data;
                REG_LEAVING_LIMIT: leaving_limit_next = cfg_data;
                default:
                begin
                    coming_window_next = coming_window_reg;
                    leaving_limit_next = leaving_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
            coming_window_reg <= COMING_WINDOW_RST;
            leaving_limit_reg <= LEAVING_LIMIT_RST;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            out_valid_reg     <= out_valid_next;
            coming_window_reg <= coming_window_next;
            leaving_limit_reg <= leaving_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (load_out)
        begin
            aim_valid_reg   <= res_reg.aim_valid;
            plate_index_reg <= res_reg.plate_index;
        end
        if (in_accept)
        begin
            slow_reg     <= slow_in;
            outpost_reg  <= is_outpost;
            turn_pos_reg <= !turn_rate[RATE_W-1] && (turn_rate != '0);
            turn_neg_reg <= turn_rate[RATE_W-1];
            count_reg    <= count_in;
            for (int i = 0; i < MAX_PLATES; i++)
            begin
                yaw_reg[i] <= yaw_in[i];
            end
        end
    end

    aaps_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cordic_start),
        .center_x (center_x),
        .center_z (center_z),
        .busy     (cordic_busy),
        .done     (cordic_done),
        .angle    (hub_angle)
    );

    aaps_plate_eval #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_plate_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (plate_ctrl),
        .center        (hub_angle),
        .yaw           (yaw_reg[cnt_reg[PIDX_W-1:0]]),
        .plate_id      (PLATE_W'(cnt_reg)),
        .slow_mode     (slow_reg),
        .outpost       (outpost_reg),
        .turn_pos      (turn_pos_reg),
        .turn_neg      (turn_neg_reg),
        .coming_window (coming_window_reg),
        .leaving_limit (leaving_limit_reg),
        .result        (plate_res)
    );

    assign out_valid   = out_valid_reg;
    assign aim_valid   = aim_valid_reg;
    assign plate_index = plate_index_reg;

    `AAPS_NEVER(a_cordic_outside_item, cordic_busy && (state_reg != ST_CORDIC),
                "CORDIC running while the sequencer is not waiting on it")
    `AAPS_ASSERT(a_unjumped_plate0, (in_accept && !jumped)
                 |=> ((state_reg == ST_RESULT) && res_reg.aim_valid &&
                      (res_reg.plate_index == '0)),
                 "item without a plate switch did not select plate 0")
    `AAPS_ASSERT(a_invalid_index_zero, (out_valid && !aim_valid) |-> (plate_index == '0),
                 "invalid aim carries a nonzero plate index")

endmodule

FILE: tb/tb_armor_aim_point_selector_top.sv
// Self-checking testbench for the armor aim point selector: directed and random targets.
`timescale 1ns / 100ps

module tb_armor_aim_point_selector_top;
    import aaps_pkg::*;

    localparam int PLATES      = 4;
    localparam int KEEP_BAM    = (TH60_Q24 + (1 << 7)) >> 8;
    localparam int OUTPOST_WIN = (TH70_Q24 + (1 << 7)) >> 8;
    localparam int OUTPOST_LVE = (TH30_Q24 + (1 << 7)) >> 8;
    localparam int SHOW_LIMIT  = 10;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 70;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cz;
        logic signed [RATE_W-1:0]  turn;
        logic signed [RATE_W-1:0]  spin;
        logic                      outpost;
        logic                      jumped;
        logic [COUNT_W-1:0]        count;
        logic [3:0][YAW_W-1:0]     yaw;
    } target_t;

    class aim_scoreboard;
        logic [CFG_W-1:0]  window_reg;
        logic [CFG_W-1:0]  leave_reg;
        logic [LOCK_W-1:0] lock;
        aim_result_t       expected_aims[$];
        logic [ACC_W-1:0]  arc_step[CORDIC_ITERS];
        int                faults;
        int                shown;

        function new();
            window_reg = COMING_WINDOW_RST;
            leave_reg  = LEAVING_LIMIT_RST;
            lock       = NO_LOCK;
            faults     = 0;
            shown      = 0;
            arc_step   = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                           32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                           32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                           32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                           32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                           32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
        endfunction

        function void report(string msg);
            faults++;
            if (shown < SHOW_LIMIT)
            begin
                shown++;
                $display("%t: %s", $realtime, msg);
            end
        endfunction

        // Vectoring CORDIC, accumulator in 2^-32 turn, rounded to 16-bit binary angle.
        function logic [YAW_W-1:0] centre_yaw(logic signed [COORD_W-1:0] px,
                                              logic signed [COORD_W-1:0] pz);
            longint           x;
            longint           y;
            longint           xs;
            longint           ys;
            logic [ACC_W-1:0] acc;
            logic [ACC_W:0]   rounded;
            if (px == 0 && pz == 0)
                return '0;
            x = px;
            y = pz;
            x = x <<< PRESCALE;
            y = y <<< PRESCALE;
            acc = '0;
            if (x < 0)
            begin
                x   = -x;
                y   = -y;
                acc = 32'h80000000;
            end
            for (int i = 0; i < CORDIC_ITERS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x   = x + ys;
                    y   = y - xs;
                    acc = acc + arc_step[i];
                end
                else
                begin
                    x   = x - ys;
                    y   = y + xs;
                    acc = acc - arc_step[i];
                end
            end
            rounded = {1'b0, acc} + 33'd32768;
            return rounded[ACC_W-1 -: YAW_W];
        endfunction

        function aim_result_t pick_plate(target_t t);
            aim_result_t             res;
            logic [YAW_W-1:0]        centre;
            logic signed [YAW_W-1:0] wrapped;
            int                      n;
            int                      delta[PLATES];
            int                      mag[PLATES];
            int                      ids[PLATES];
            int                      nc;
            int                      win;
            int                      leave;
            res = '0;
            if (!t.jumped)
            begin
                res.aim_valid = 1'b1;
                return res;
            end
            n = (t.count > PLATES) ? PLATES : int'(t.count);
            centre = centre_yaw(t.cx, t.cz);
            for (int i = 0; i < n; i++)
            begin
                wrapped  = t.yaw[i] - centre;
                delta[i] = wrapped;
                mag[i]   = (delta[i] < 0) ? -delta[i] : delta[i];
            end
            if (t.spin >= -SLOW_SPIN_LIMIT && t.spin <= SLOW_SPIN_LIMIT && !t.outpost)
            begin
                nc = 0;
                for (int i = 0; i < n; i++)
                    if (mag[i] <= KEEP_BAM)
                    begin
                        ids[nc] = i;
                        nc++;
                    end
                if (nc == 0)
                    return res;
                res.aim_valid = 1'b1;
                if (nc > 1)
                begin
                    // hold the lock while it is one of the two leading candidates
                    if (int'(lock) != ids[0] && int'(lock) != ids[1])
                        lock = (mag[ids[0]] < mag[ids[1]]) ? LOCK_W'(ids[0]) : LOCK_W'(ids[1]);
                    res.plate_index = lock[PLATE_W-1:0];
                end
                else
                begin
                    lock = NO_LOCK;
                    res.plate_index = PLATE_W'(ids[0]);
                end
                return res;
            end
            win   = t.outpost ? OUTPOST_WIN : int'(window_reg);
            leave = t.outpost ? OUTPOST_LVE : int'(leave_reg);
            for (int i = 0; i < n; i++)
            begin
                if (mag[i] > win)
                    continue;
                if ((t.turn > 0 && delta[i] < leave) || (t.turn < 0 && delta[i] > -leave))
                begin
                    res.aim_valid   = 1'b1;
                    res.plate_index = PLATE_W'(i);
                    return res;
                end
            end
            return res;
        endfunction

        function void take_target(target_t t);
            expected_aims.insert(expected_aims.size(), pick_plate(t));
        endfunction

        function void take_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_COMING_WINDOW: window_reg = val;
                REG_LEAVING_LIMIT: leave_reg  = val;
                default: ;
            endcase
        endfunction

        function void check_aim(logic got_valid, logic [PLATE_W-1:0] got_index);
            aim_result_t want;
            if (expected_aims.size() == 0)
            begin
                report($sformatf("result with nothing pending: aim_valid %b plate_index %0d",
                                 got_valid, got_index));
                return;
            end
            want = expected_aims.pop_front();
            if (want.aim_valid !== got_valid)
                report($sformatf("aim_valid mismatch: expected %b, got %b",
                                 want.aim_valid, got_valid));
            if (want.plate_index !== got_index)
                report($sformatf("plate_index mismatch: expected %0d, got %0d",
                                 want.plate_index, got_index));
        endfunction

        function int pending();
            return expected_aims.size();
        endfunction

        function void close_out();
            if (expected_aims.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_aims.size()));
        endfunction
    endclass

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic signed [COORD_W-1:0] center_x    = '0;
    logic signed [COORD_W-1:0] center_z    = '0;
    logic signed [RATE_W-1:0]  turn_rate   = '0;
    logic signed [RATE_W-1:0]  spin_rate   = '0;
    logic                      is_outpost  = 1'b0;
    logic                      jumped      = 1'b0;
    logic [COUNT_W-1:0]        armor_count = '0;
    logic signed [YAW_W-1:0]   armor_yaw_0 = '0;
    logic signed [YAW_W-1:0]   armor_yaw_1 = '0;
    logic signed [YAW_W-1:0]   armor_yaw_2 = '0;
    logic signed [YAW_W-1:0]   armor_yaw_3 = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic                      aim_valid;
    logic [PLATE_W-1:0]        plate_index;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index   = REG_COMING_WINDOW;
    logic [CFG_W-1:0]          cfg_data    = '0;

    aim_scoreboard sb;
    int            fed    = 0;
    bit            steady = 1'b0;

    armor_aim_point_selector_top dut (.*);

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_aim(aim_valid, plate_index);

    // Result side: random stall ahead of every transaction, none in the steady stretch.
    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = steady ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input target_t t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        center_x    <= t.cx;
        center_z    <= t.cz;
        turn_rate   <= t.turn;
        spin_rate   <= t.spin;
        is_outpost  <= t.outpost;
        jumped      <= t.jumped;
        armor_count <= t.count;
        armor_yaw_0 <= t.yaw[0];
        armor_yaw_1 <= t.yaw[1];
        armor_yaw_2 <= t.yaw[2];
        armor_yaw_3 <= t.yaw[3];
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.take_target(t);
        fed++;
    endtask

    // Drop valid and hold until every pending result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic apply_tuning(input int cw, input int ll, input bit poke_spare);
        logic [CFG_IDX_W-1:0] idx[3];
        logic [CFG_W-1:0]     val[3];
        int                   first;
        idx   = '{REG_SPARE, REG_COMING_WINDOW, REG_LEAVING_LIMIT};
        val   = '{15'h7FFF, CFG_W'(cw), CFG_W'(ll)};
        first = poke_spare ? 0 : 1;
        cfg_valid <= 1'b1;
        for (int k = first; k < 3; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            sb.take_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Target with plate yaws given as offsets from the centre yaw.
    function automatic target_t aimed(int cx, int cz, int turn, int spin, bit outpost,
                                      int count, int o0, int o1, int o2, int o3);
        target_t          t;
        logic [YAW_W-1:0] centre;
        t.cx      = COORD_W'(cx);
        t.cz      = COORD_W'(cz);
        t.turn    = RATE_W'(turn);
        t.spin    = RATE_W'(spin);
        t.outpost = outpost;
        t.jumped  = 1'b1;
        t.count   = COUNT_W'(count);
        centre    = sb.centre_yaw(t.cx, t.cz);
        t.yaw[0]  = centre + YAW_W'(o0);
        t.yaw[1]  = centre + YAW_W'(o1);
        t.yaw[2]  = centre + YAW_W'(o2);
        t.yaw[3]  = centre + YAW_W'(o3);
        return t;
    endfunction

    function automatic target_t noise();
        target_t t;
        t.cx      = COORD_W'($urandom);
        t.cz      = COORD_W'($urandom);
        t.turn    = RATE_W'($urandom);
        t.spin    = RATE_W'($urandom);
        t.outpost = 1'($urandom_range(0, 1));
        t.jumped  = ($urandom_range(0, 3) != 0);
        t.count   = COUNT_W'($urandom_range(0, 7));
        for (int i = 0; i < 4; i++)
            t.yaw[i] = YAW_W'($urandom);
        return t;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return 16'hFFFF;
            4: return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, 8000) - 4000);
        endcase
    endfunction

    task automatic run_directed();
        target_t t;
        t = aimed(-32768, -32768, -32768, -32768, 1, 0, 0, 0, 0, 0);
        t.jumped = 1'b0;
        send_item(t);
        t = aimed(32767, 32767, 32767, 32767, 0, 7, 32767, -32768, 1, -1);
        t.jumped = 1'b0;
        send_item(t);
        send_item(aimed(0, 0, 256, 0, 0, 4, 0, 16384, -32768, -16384));
        send_item(aimed(1000, 1000, 256, 0, 0, 2, -5000, 5000, 0, 0));
        send_item(aimed(1000, 1000, 256, 0, 0, 2, -4000, 6000, 0, 0));
        send_item(aimed(1000, 1000, 256, 0, 0, 3, -3000, 20000, 3000, 0));
        send_item(aimed(-1, 0, 256, 0, 0, 4, 10923, 10922, -10922, 0));
        send_item(aimed(-1000, -200, 256, 0, 0, 4, -10923, 30000, 10922, -30000));
        send_item(aimed(5, -7, 256, 512, 0, 2, 20000, -20000, 0, 0));
        // offset of exactly a half turn
        send_item(aimed(0, -32768, 256, -512, 0, 4, 32768, 16384, 0, -16384));
        send_item(aimed(300, 400, 0, 513, 0, 4, 0, 1000, -1000, 0));
        send_item(aimed(300, 400, 1, -513, 0, 3, -20000, 3641, 3640, 0));
        send_item(aimed(-32768, 32767, -1, 32767, 0, 4, -3641, -3640, 0, 0));
        send_item(aimed(32767, -32768, 32767, -32768, 0, 4, 10924, -10923, 0, 0));
        send_item(aimed(2000, -3000, -32768, 0, 1, 3, 12743, -12742, 5000, 0));
        send_item(aimed(-5, 5, 100, 4000, 1, 3, 5461, 5460, 0, 0));
        send_item(aimed(10, 10, 1, 1000, 0, 0, 0, 0, 0, 0));
        send_item(aimed(10, -10, 1, 1000, 0, 5, 20000, 20000, 20000, 100));
        send_item(aimed(-300, 77, 5, 0, 0, 6, 30000, 9000, -9000, 100));
        send_item(aimed(0, 32767, -1, 20000, 0, 7, 30000, 30000, 30000, -100));
        send_item(aimed(32767, 0, 1, 0, 0, 4, -30000, 2000, 30000, 0));
        send_item(aimed(0, -1, 0, 0, 1, 4, 0, 0, 0, 0));
    endtask

    // Plates sitting exactly on the window and leaving limits, and one step beside them.
    task automatic probe_limits(input int cw, input int ll);
        send_item(aimed(1200, -800, 5, 9000, 0, 4, cw, -cw, ll, ll - 1));
        send_item(aimed(-1200, 800, -5, -9000, 0, 4, cw + 1, -(cw + 1), -ll, -ll + 1));
    endtask

    // Several frames of one target: plates evenly spaced, slowly rotating.
    task automatic run_track();
        target_t          t;
        logic [YAW_W-1:0] centre;
        int               len;
        int               spacing;
        int               base;
        int               drift;
        int               jitter;
        int               spin;
        len       = $urandom_range(3, 8);
        t.cx      = pick_coord();
        t.cz      = pick_coord();
        t.outpost = ($urandom_range(0, 4) == 0);
        t.jumped  = 1'b1;
        t.count   = t.outpost ? COUNT_W'(3) : (($urandom_range(0, 3) == 0) ? COUNT_W'(2)
                                                                             : COUNT_W'(4));
        spacing   = 65536 / int'(t.count);
        if ($urandom_range(0, 1))
            spin = $urandom_range(0, 1024) - 512;
        else
        begin
            spin = $urandom_range(513, 32767);
            if ($urandom_range(0, 1))
                spin = -spin;
        end
        t.spin = RATE_W'(spin);
        t.turn = ($urandom_range(0, 9) == 0) ? '0 : RATE_W'($urandom);
        base   = $urandom_range(0, 65535);
        drift  = $urandom_range(0, 3000) - 1500;
        centre = sb.centre_yaw(t.cx, t.cz);
        for (int k = 0; k < len; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                jitter   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) - 200 : 0;
                t.yaw[i] = centre + YAW_W'(base + i * spacing + jitter);
            end
            send_item(t);
            base = base + drift;
        end
    endtask

    initial
    begin
        int      window_plan[PHASES];
        int      leave_plan[PHASES];
        int      phase_start;
        int      k;
        bit      paused;
        target_t t;
        window_plan = '{10923, 32767, 0, 6000, 32767, 10923};
        leave_plan  = '{3641, 0, 32767, 2500, 32767, 3641};
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                apply_tuning(window_plan[p], leave_plan[p], p == 2);
            end
            probe_limits(window_plan[p], leave_plan[p]);
            phase_start = fed;
            paused      = 1'b0;
            while (fed - phase_start < PHASE_ITEMS)
            begin
                steady = (fed - phase_start >= 40) && (fed - phase_start < 55);
                if (!paused && fed - phase_start >= 25)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0, 1: send_item(noise());
                    2:
                    begin
                        t = noise();
                        t.jumped = 1'b0;
                        send_item(t);
                    end
                    default: run_track();
                endcase
            end
            steady = 1'b0;
        end
        in_valid <= 1'b0;
        k = 0;
        do
        begin
            @(posedge clk);
            k++;
        end
        while (sb.pending() != 0 && k < 4000);
        repeat (40) @(posedge clk);
        sb.close_out();
        if (sb.faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: armor_aim_point_selector_top.f
+incdir+sv
sv/aaps_pkg.sv
sv/aaps_cordic.sv
sv/aaps_plate_eval.sv
sv/armor_aim_point_selector_top.sv
tb/tb_armor_aim_point_selector_top.sv
